>>> rtl/core/tcbfs_pkg.sv
// package for the two-color bfs meeting distance block
// shared sizes, state encoding and status codes; no dependencies
package tcbfs_pkg;
   localparam int MaxNodes = 256;
   localparam int MaxEdges = 1024;
   localparam int NodeW = $clog2(MaxNodes);
   localparam int EdgeW = $clog2(MaxEdges);
   localparam int CountW = NodeW + 1;
   localparam int TotalW = EdgeW + 1;
   localparam int DistW = 9;

   localparam logic [1:0] StEdgeStored = 2'd0;
   localparam logic [1:0] StEdgeDropped = 2'd1;
   localparam logic [1:0] StFound = 2'd2;
   localparam logic [1:0] StNone = 2'd3;

   localparam logic OpAdd = 1'b0;
   localparam logic OpQuery = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_POP,
      S_POPWAIT,
      S_SCAN,
      S_SCANWAIT,
      S_SCANDO,
      S_NEXTWALK,
      S_SUM,
      S_SUMWAIT,
      S_SUMDO,
      S_DONE
   } state_type;
endpackage

>>> rtl/core/two_color_bfs_meeting_distance.sv
// channel  | dir | fields (tdata, low bit first)
// req      | in  | operation, first_node, second_node, edge_color (18 bits in 24)
// rsp      | out | status, best_total (11 bits in 16)
// csr      | in  | node_count (9 bits)
// an edge add is answered directly from idle; a query runs a red search from first_node, then
// a blue search from second_node (each skipped when its start is out of range), each popping
// nodes and scanning every stored edge per popped node, then a final sum over all nodes
// reset is synchronous; edge count returns to zero, the edge store keeps its data
// req_tready is low while a result waits or a query runs
// depends on tcbfs_pkg
module two_color_bfs_meeting_distance (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // operation, first_node, second_node, edge_color
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // status, best_total
   input  logic        csr_wr_en,
   input  logic [8:0]  csr_wr_data
);
   import tcbfs_pkg::*;

   logic [16:0] edge_mem [MaxEdges];
   logic [16:0] edge_rd_ff;
   logic [DistW-1:0] red_mem [MaxNodes];
   logic [DistW-1:0] blue_mem [MaxNodes];
   logic [DistW-1:0] red_rd_ff, blue_rd_ff;
   logic [NodeW-1:0] queue_mem [MaxNodes];
   logic [NodeW-1:0] queue_rd_ff;
   logic [MaxNodes-1:0] seen_ff, seen_in;
   logic [MaxNodes-1:0] rseen_ff, rseen_in;

   state_type state_ff, state_in;
   logic [TotalW-1:0] edge_total_ff, edge_total_in;
   logic [CountW-1:0] node_count_ff, node_count_in;
   logic [NodeW-1:0] src_ff, src_in, dst_ff, dst_in;
   logic color_ff, color_in;
   logic [CountW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [NodeW-1:0] cur_ff, cur_in;
   logic [DistW-1:0] cur_dist_ff, cur_dist_in;
   logic [TotalW-1:0] eidx_ff, eidx_in;
   logic [CountW-1:0] idx_ff, idx_in;
   logic found_ff, found_in;
   logic [DistW:0] best_ff, best_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [DistW-1:0] rsp_total_ff, rsp_total_in;

   // memory controls
   logic edge_we;
   logic [EdgeW-1:0] edge_addr;
   logic [16:0] edge_wdata;
   logic dist_we;
   logic [NodeW-1:0] dist_waddr, dist_raddr;
   logic [DistW-1:0] dist_wdata;
   logic q_we;
   logic [NodeW-1:0] q_waddr, q_raddr;
   logic [NodeW-1:0] q_wdata;

   logic req_fire;
   logic [NodeW-1:0] ea, eb, other;
   logic hit;
   logic [CountW-1:0] tail_cap;
   logic [DistW:0] sum;
   logic [NodeW-1:0] idx_n;

   assign req_fire = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {5'd0, rsp_total_ff, rsp_status_ff};

   assign ea = edge_rd_ff[16:9];
   assign eb = edge_rd_ff[8:1];
   assign tail_cap = CountW'(MaxNodes);
   assign idx_n = idx_ff[NodeW-1:0];
   assign sum = {1'b0, red_rd_ff} + {1'b0, blue_rd_ff};

   always_ff @(posedge clock) begin
      if (edge_we) edge_mem[edge_addr] <= edge_wdata;
      edge_rd_ff <= edge_mem[edge_addr];
   end

   always_ff @(posedge clock) begin
      if (dist_we && !color_ff) red_mem[dist_waddr] <= dist_wdata;
      if (dist_we && color_ff) blue_mem[dist_waddr] <= dist_wdata;
      red_rd_ff <= red_mem[dist_raddr];
      blue_rd_ff <= blue_mem[dist_raddr];
   end

   always_ff @(posedge clock) begin
      if (q_we) queue_mem[q_waddr] <= q_wdata;
      queue_rd_ff <= queue_mem[q_raddr];
   end

   always_comb begin
      hit = 1'b0;
      other = ea;
      if (edge_rd_ff[0] == color_ff && CountW'(ea) < node_count_ff
          && CountW'(eb) < node_count_ff) begin
         if (ea == cur_ff) begin
            hit = 1'b1;
            other = eb;
         end else if (eb == cur_ff) begin
            hit = 1'b1;
            other = ea;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && req_tdata[0] == OpQuery) state_in = S_START;
         end
         S_START: begin
            if (CountW'(color_ff ? dst_ff : src_ff) < node_count_ff) state_in = S_POP;
            else state_in = S_NEXTWALK;
         end
         S_POP: begin
            if (head_ff < tail_ff) state_in = S_POPWAIT;
            else state_in = S_NEXTWALK;
         end
         S_POPWAIT: state_in = S_SCAN;
         S_SCAN: begin
            if (eidx_ff < edge_total_ff) state_in = S_SCANWAIT;
            else state_in = S_POP;
         end
         S_SCANWAIT: state_in = S_SCANDO;
         S_SCANDO: state_in = S_SCAN;
         S_NEXTWALK: state_in = color_ff ? S_SUM : S_START;
         S_SUM: begin
            if (idx_ff < node_count_ff) state_in = S_SUMWAIT;
            else state_in = S_DONE;
         end
         S_SUMWAIT: state_in = S_SUMDO;
         S_SUMDO: state_in = S_SUM;
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      edge_total_in = edge_total_ff;
      node_count_in = node_count_ff;
      src_in = src_ff;
      dst_in = dst_ff;
      color_in = color_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      cur_in = cur_ff;
      cur_dist_in = cur_dist_ff;
      eidx_in = eidx_ff;
      idx_in = idx_ff;
      found_in = found_ff;
      best_in = best_ff;
      seen_in = seen_ff;
      rseen_in = rseen_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_total_in = rsp_total_ff;
      edge_we = 1'b0;
      edge_addr = eidx_ff[EdgeW-1:0];
      edge_wdata = {req_tdata[8:1], req_tdata[16:9], req_tdata[17]};
      dist_we = 1'b0;
      dist_waddr = cur_ff;
      dist_wdata = '0;
      dist_raddr = cur_ff;
      q_we = 1'b0;
      q_waddr = tail_ff[NodeW-1:0];
      q_wdata = other;
      q_raddr = head_ff[NodeW-1:0];

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (csr_wr_en) begin
         if (csr_wr_data == '0) node_count_in = CountW'(1);
         else if (32'(csr_wr_data) > MaxNodes) node_count_in = CountW'(MaxNodes);
         else node_count_in = CountW'(csr_wr_data);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_tdata[0] == OpAdd) begin
                  rsp_valid_in = 1'b1;
                  rsp_total_in = '0;
                  if (32'(edge_total_ff) >= MaxEdges) begin
                     rsp_status_in = StEdgeDropped;
                  end else begin
                     edge_we = 1'b1;
                     edge_addr = edge_total_ff[EdgeW-1:0];
                     edge_total_in = edge_total_ff + 1'b1;
                     rsp_status_in = StEdgeStored;
                  end
               end else begin
                  src_in = req_tdata[8:1];
                  dst_in = req_tdata[16:9];
                  color_in = 1'b0;
               end
            end
         end
         S_START: begin
            seen_in = '0;
            head_in = '0;
            tail_in = '0;
            if (CountW'(color_ff ? dst_ff : src_ff) < node_count_ff) begin
               seen_in[color_ff ? dst_ff : src_ff] = 1'b1;
               q_we = 1'b1;
               q_waddr = '0;
               q_wdata = color_ff ? dst_ff : src_ff;
               dist_we = 1'b1;
               dist_waddr = color_ff ? dst_ff : src_ff;
               tail_in = CountW'(1);
            end
         end
         S_POP: begin
            q_raddr = head_ff[NodeW-1:0];
         end
         S_POPWAIT: begin
            cur_in = queue_rd_ff;
            head_in = head_ff + 1'b1;
            eidx_in = '0;
            dist_raddr = queue_rd_ff;
         end
         S_SCAN: begin
            cur_dist_in = color_ff ? blue_rd_ff : red_rd_ff;
            if (eidx_ff != '0) cur_dist_in = cur_dist_ff;
            edge_addr = eidx_ff[EdgeW-1:0];
         end
         S_SCANWAIT: begin
            eidx_in = eidx_ff + 1'b1;
         end
         S_SCANDO: begin
            if (hit && !seen_ff[other] && tail_ff < tail_cap) begin
               seen_in[other] = 1'b1;
               dist_we = 1'b1;
               dist_waddr = other;
               dist_wdata = cur_dist_ff + 1'b1;
               q_we = 1'b1;
               q_waddr = tail_ff[NodeW-1:0];
               tail_in = tail_ff + 1'b1;
            end
         end
         S_NEXTWALK: begin
            if (!color_ff) begin
               rseen_in = seen_ff;
               color_in = 1'b1;
            end
            idx_in = '0;
            found_in = 1'b0;
            best_in = '0;
         end
         S_SUM: begin
            dist_raddr = idx_n;
         end
         S_SUMWAIT: begin
            dist_raddr = idx_n;
         end
         S_SUMDO: begin
            if (idx_n != src_ff && idx_n != dst_ff && rseen_ff[idx_n] && seen_ff[idx_n]) begin
               if (!found_ff || sum < best_in) begin
                  best_in = sum;
                  found_in = 1'b1;
               end
            end
            idx_in = idx_ff + 1'b1;
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_status_in = found_ff ? StFound : StNone;
            rsp_total_in = found_ff ? (best_ff[DistW] ? '1 : best_ff[DistW-1:0]) : '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         edge_total_ff <= '0;
         node_count_ff <= CountW'(MaxNodes);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         edge_total_ff <= edge_total_in;
         node_count_ff <= node_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      src_ff <= src_in;
      dst_ff <= dst_in;
      color_ff <= color_in;
      head_ff <= head_in;
      tail_ff <= tail_in;
      cur_ff <= cur_in;
      cur_dist_ff <= cur_dist_in;
      eidx_ff <= eidx_in;
      idx_ff <= idx_in;
      found_ff <= found_in;
      best_ff <= best_in;
      seen_ff <= seen_in;
      rseen_ff <= rseen_in;
      rsp_status_ff <= rsp_status_in;
      rsp_total_ff <= rsp_total_in;
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == S_IDLE) else $error("ready outside idle");
   a_total_cap: assert property (@(posedge clock) disable iff (reset)
      32'(edge_total_ff) <= MaxEdges) else $error("edge count overflow");
   a_head_tail: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> head_ff <= tail_ff) else $error("queue underflow");
   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |=> rsp_valid_ff) else $error("query lost");
endmodule
